[rtl/sprite_rle_unpacker_assert.svh]
// Assertion macros for the sprite RLE unpacker checker.
// Depends on nothing; expects signals named clk and rst_n where it is used.
`ifndef SPRITE_RLE_UNPACKER_ASSERT_SVH
`define SPRITE_RLE_UNPACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite_rle_unpacker: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite_rle_unpacker: next-cycle check failed");

`endif

[rtl/sru_pkg.sv]
// Shared types and constants for the sprite RLE unpacker.
// Used by the front parser, the command queue, the write expander and the top level.
package sru_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 8192;
    localparam int FIFO_DEPTH           = 4;
    localparam int ROM_W                = 27;
    localparam int REQ_W                = 13;
    localparam int LEN_W                = 8;
    localparam int OUT_IDX_W            = 13;
    localparam logic [ROM_W-1:0] ROM_MASK_RESET = '1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CTRL = 2'd1,
        PH_LIT  = 2'd2,
        PH_REP  = 2'd3
    } phase_t;

    // One decoded run handed from the parser to the expander.
    typedef struct packed {
        logic [7:0]       value;
        logic [LEN_W-1:0] len;      // pixels still to write; zero for an empty request
        logic             done;     // the request completes with this run
        logic             visible;
        logic [ROM_W-1:0] end_off;
    } cmd_t;

endpackage

[rtl/sprite_rle_unpacker.sv]
// Top level of the sprite RLE unpacker: ports, configuration register and wiring.
// Depends on sru_pkg, sru_front, sru_cmd_fifo and sru_back.
//
// Usage. Graphics ROM bytes enter on the slave stream, one transaction per byte. The
// first byte of a sprite request carries begin_sprite in s_tuser, together with the
// pixel count wanted and the ROM start offset in the upper bits of s_tdata. Each
// control byte opens a packet; literal packets give one write per byte, repeat packets
// give writes of up to two pixels from one value byte, one per unstalled cycle. Writes
// leave on the master stream; m_tlast marks the last write caused by one input byte and
// m_tuser the write that completes the request, which also carries any_visible and
// end_offset. The ROM address mask is written on the cfg channel, which is always ready;
// write it only while no request is in flight.
// With the queue and expander empty, a write reaches the master stream from the byte that
// causes it through the queue entry at the accepting edge, then the expander register,
// then the output register.
// Throughput: one input byte per cycle while the command queue has room. A repeat
// packet occupies the expander until all its pixels are written; the four-entry queue
// absorbs this and s_tready falls only once it is full.
// Reset clears the request state, empties the queue and sets the mask to all ones.
// When the receiver stalls, the output register holds its write, the expander stops,
// the queue fills and the slave side stalls in turn; no transaction is lost.
module sprite_rle_unpacker
    import sru_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Configuration: rom_address_mask
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ROM_W-1:0] cfg_data,
    // Input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    // data_byte [7:0], request_pixels [20:8], start_offset [47:21]
    input  logic [47:0]      s_tdata,
    // begin_sprite [0]
    input  logic             s_tuser,
    // Output stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // dest_index [12:0], pixel_first [20:13], pixel_second [28:21],
    // pixel_count [30:29], any_visible [31], end_offset [58:32], zero [63:59]
    output logic [63:0]      m_tdata,
    // sprite_done [0]
    output logic             m_tuser,
    // run_last
    output logic             m_tlast
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    logic [ROM_W-1:0] mask_reg;

    logic             in_accept;
    logic             fifo_full;
    logic             push;
    cmd_t             push_cmd;
    logic [IDX_W-1:0] push_idx;
    logic             pop;
    logic             head_valid;
    cmd_t             head_cmd;
    logic [IDX_W-1:0] head_idx;

    logic [OUT_IDX_W-1:0] dest_index;
    logic [7:0]           pixel_first;
    logic [7:0]           pixel_second;
    logic [1:0]           pixel_count;
    logic                 any_visible;
    logic [ROM_W-1:0]     end_offset;

    // The mask register takes every write at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= ROM_MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mask_reg <= cfg_data;
        end
    end

    // Every byte, including control bytes that produce no command, waits for queue room.
    assign s_tready  = !fifo_full;
    assign in_accept = s_tvalid && s_tready;

    sru_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .IDX_W        (IDX_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_accept      (in_accept),
        .data_byte      (s_tdata[7:0]),
        .begin_sprite   (s_tuser),
        .request_pixels (s_tdata[20:8]),
        .start_offset   (s_tdata[47:21]),
        .rom_mask       (mask_reg),
        .push           (push),
        .push_cmd       (push_cmd),
        .push_idx       (push_idx)
    );

    sru_cmd_fifo #(
        .IDX_W (IDX_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_idx   (push_idx),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_idx   (head_idx)
    );

    sru_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .IDX_W        (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .head_idx     (head_idx),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .dest_index   (dest_index),
        .pixel_first  (pixel_first),
        .pixel_second (pixel_second),
        .pixel_count  (pixel_count),
        .run_last     (m_tlast),
        .sprite_done  (m_tuser),
        .any_visible  (any_visible),
        .end_offset   (end_offset)
    );

    assign m_tdata = {5'd0, end_offset, any_visible, pixel_count,
                      pixel_second, pixel_first, dest_index};

endmodule

[rtl/sru_cmd_fifo.sv]
// Short command queue between the parser and the write expander.
// Depends on sru_pkg for cmd_t and FIFO_DEPTH.
module sru_cmd_fifo
    import sru_pkg::*;
#(
    parameter int IDX_W = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cmd_t             push_cmd,
    input  logic [IDX_W-1:0] push_idx,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cmd_t             head_cmd,
    output logic [IDX_W-1:0] head_idx
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             cmd_mem [FIFO_DEPTH];
    logic [IDX_W-1:0] idx_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = cmd_mem[rd_ptr_reg];
    assign head_idx   = idx_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem[wr_ptr_reg] <= push_cmd;
            idx_mem[wr_ptr_reg] <= push_idx;
        end
    end

endmodule

[rtl/sru_front.sv]
// Parser: classifies each ROM byte, tracks packet and request state, emits run commands.
// Depends on sru_pkg for phase_t, cmd_t and widths.
module sru_front
    import sru_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
    parameter int IDX_W        = $clog2(BUFFER_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_accept,
    input  logic [7:0]       data_byte,
    input  logic             begin_sprite,
    input  logic [REQ_W-1:0] request_pixels,
    input  logic [ROM_W-1:0] start_offset,
    input  logic [ROM_W-1:0] rom_mask,
    output logic             push,
    output cmd_t             push_cmd,
    output logic [IDX_W-1:0] push_idx
);

    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(BUFFER_DEPTH);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] packet_reg, packet_next;
    logic [REQ_W-1:0] pixels_reg, pixels_next;
    logic [IDX_W-1:0] wptr_reg, wptr_next;
    logic [ROM_W-1:0] rom_pos_reg, rom_pos_next;
    logic             seen_reg, seen_next;

    logic [ROM_W-1:0] rom_adv;
    logic [LEN_W-1:0] run;
    logic [IDX_W:0]   wsum;
    logic             lit_done;

    always_comb
    begin
        phase_next   = phase_reg;
        packet_next  = packet_reg;
        pixels_next  = pixels_reg;
        wptr_next    = wptr_reg;
        rom_pos_next = rom_pos_reg;
        seen_next    = seen_reg;
        push         = 1'b0;
        push_cmd     = '0;
        push_idx     = '0;
        rom_adv      = '0;
        run          = {1'b0, data_byte[6:0]} + LEN_W'(1);
        wsum         = '0;
        lit_done     = 1'b0;

        if (in_accept)
        begin
            // A begin marker abandons whatever request was running.
            if (begin_sprite)
            begin
                pixels_next  = request_pixels;
                rom_pos_next = start_offset & rom_mask;
                wptr_next    = '0;
                seen_next    = 1'b0;
                packet_next  = '0;
                if (request_pixels == '0)
                begin
                    phase_next       = PH_IDLE;
                    push             = 1'b1;
                    push_cmd.done    = 1'b1;
                    push_cmd.end_off = start_offset & rom_mask;
                end
                else
                begin
                    phase_next = PH_CTRL;
                end
            end

            rom_adv = (rom_pos_next + ROM_W'(1)) & rom_mask;

            unique case (phase_next)
                PH_IDLE:
                begin
                end
                PH_CTRL:
                begin
                    rom_pos_next = rom_adv;
                    pixels_next  = (pixels_next > REQ_W'(run)) ?
                                   pixels_next - REQ_W'(run) : '0;
                    packet_next  = run;
                    if (run == LEN_W'(1) || data_byte[7])
                    begin
                        seen_next  = 1'b1;
                        phase_next = PH_LIT;
                    end
                    else
                    begin
                        phase_next = PH_REP;
                    end
                end
                PH_LIT:
                begin
                    rom_pos_next     = rom_adv;
                    packet_next      = packet_next - LEN_W'(1);
                    lit_done         = (packet_next == '0) && (pixels_next == '0);
                    push             = 1'b1;
                    push_cmd.value   = data_byte;
                    push_cmd.len     = LEN_W'(1);
                    push_cmd.done    = lit_done;
                    push_cmd.visible = seen_next;
                    push_cmd.end_off = rom_adv;
                    push_idx         = wptr_next;
                    wsum             = {1'b0, wptr_next} + (IDX_W + 1)'(1);
                    wptr_next        = (wsum >= DEPTH_W) ? IDX_W'(wsum - DEPTH_W) : IDX_W'(wsum);
                    if (packet_next == '0)
                    begin
                        phase_next = lit_done ? PH_IDLE : PH_CTRL;
                    end
                end
                PH_REP:
                begin
                    rom_pos_next = rom_adv;
                    if (data_byte != 8'd0)
                    begin
                        seen_next = 1'b1;
                    end
                    push             = 1'b1;
                    push_cmd.value   = data_byte;
                    push_cmd.len     = packet_next;
                    push_cmd.done    = (pixels_next == '0);
                    push_cmd.visible = seen_next;
                    push_cmd.end_off = rom_adv;
                    push_idx         = wptr_next;
                    wsum             = {1'b0, wptr_next} + (IDX_W + 1)'(packet_next);
                    wptr_next        = (wsum >= DEPTH_W) ? IDX_W'(wsum - DEPTH_W) : IDX_W'(wsum);
                    packet_next      = '0;
                    phase_next       = (pixels_next == '0) ? PH_IDLE : PH_CTRL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            packet_reg  <= '0;
            pixels_reg  <= '0;
            wptr_reg    <= '0;
            rom_pos_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            packet_reg  <= packet_next;
            pixels_reg  <= pixels_next;
            wptr_reg    <= wptr_next;
            rom_pos_reg <= rom_pos_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

[rtl/sru_back.sv]
// Write expander: turns run commands into buffer writes of up to two pixels.
// Depends on sru_pkg for cmd_t and widths.
module sru_back
    import sru_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
    parameter int IDX_W        = $clog2(BUFFER_DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  cmd_t                 head_cmd,
    input  logic [IDX_W-1:0]     head_idx,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_IDX_W-1:0] dest_index,
    output logic [7:0]           pixel_first,
    output logic [7:0]           pixel_second,
    output logic [1:0]           pixel_count,
    output logic                 run_last,
    output logic                 sprite_done,
    output logic                 any_visible,
    output logic [ROM_W-1:0]     end_offset
);

    localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(BUFFER_DEPTH);

    logic             cur_valid_reg, cur_valid_next;
    cmd_t             cur_cmd_reg;
    logic [IDX_W-1:0] cur_idx_reg;
    logic             out_valid_reg, out_valid_next;

    logic [OUT_IDX_W-1:0] o_idx_reg;
    logic [7:0]           o_p1_reg, o_p2_reg;
    logic [1:0]           o_cnt_reg;
    logic                 o_last_reg, o_done_reg, o_vis_reg;
    logic [ROM_W-1:0]     o_end_reg;

    logic             out_free;
    logic             emit;
    logic [1:0]       cnt;
    logic [LEN_W-1:0] rem;
    logic             last;
    logic [IDX_W:0]   isum;
    logic [IDX_W-1:0] idx_adv;

    assign out_free = !out_valid_reg || out_ready;
    assign emit     = cur_valid_reg && out_free;
    assign cnt      = (cur_cmd_reg.len >= LEN_W'(2)) ? 2'd2 : cur_cmd_reg.len[1:0];
    assign rem      = cur_cmd_reg.len - LEN_W'(cnt);
    assign last     = (rem == '0);
    assign isum     = {1'b0, cur_idx_reg} + (IDX_W + 1)'(cnt);
    assign idx_adv  = (isum >= DEPTH_W) ? IDX_W'(isum - DEPTH_W) : IDX_W'(isum);
    assign pop      = head_valid && (!cur_valid_reg || (emit && last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
        end
        else if (emit && last)
        begin
            cur_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_cmd_reg <= head_cmd;
            cur_idx_reg <= head_idx;
        end
        else if (emit)
        begin
            cur_cmd_reg.len <= rem;
            cur_idx_reg     <= idx_adv;
        end
        if (emit)
        begin
            o_idx_reg  <= OUT_IDX_W'(cur_idx_reg);
            o_p1_reg   <= cur_cmd_reg.value;
            o_p2_reg   <= (cnt == 2'd2) ? cur_cmd_reg.value : 8'd0;
            o_cnt_reg  <= cnt;
            o_last_reg <= last;
            o_done_reg <= last && cur_cmd_reg.done;
            o_vis_reg  <= last && cur_cmd_reg.done && cur_cmd_reg.visible;
            o_end_reg  <= (last && cur_cmd_reg.done) ? cur_cmd_reg.end_off : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_index   = o_idx_reg;
    assign pixel_first  = o_p1_reg;
    assign pixel_second = o_p2_reg;
    assign pixel_count  = o_cnt_reg;
    assign run_last     = o_last_reg;
    assign sprite_done  = o_done_reg;
    assign any_visible  = o_vis_reg;
    assign end_offset   = o_end_reg;

endmodule

[rtl/sru_checker.sv]
// Port-level checks for the sprite RLE unpacker, attached to the top level by bind.
// Depends on sprite_rle_unpacker_assert.svh for the assertion macros.
`include "sprite_rle_unpacker_assert.svh"

module sru_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled write is held unchanged.
    `SRU_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Only the last write of a byte can complete a request.
    `SRU_ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser, m_tlast)

    // Summary fields stay zero until the request completes.
    `SRU_ASSERT_NOW(a_summary_zero, m_tvalid && !m_tuser, m_tdata[58:31] == 28'd0)

    // An empty write only reports an empty request, and a short write has no second pixel.
    `SRU_ASSERT_NOW(a_count_shape, m_tvalid && (m_tdata[30:29] != 2'd2),
                    (m_tdata[28:21] == 8'd0) && (m_tdata[30:29] != 2'd3) &&
                    ((m_tdata[30:29] != 2'd0) || (m_tuser && m_tlast)))

endmodule

bind sprite_rle_unpacker sru_checker u_sru_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sprite_rle_unpacker: streams graphics ROM bytes in and checks
// every pixel write against an in-bench decoder. Depends on sru_pkg and the RTL only.
module testbench;
    import sru_pkg::*;

    localparam int BUF_DEPTH   = BUFFER_DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 1000;   // cycles with no transaction on any channel
    localparam int DRAIN_WAIT  = 8;      // comfortably more than the three-stage latency
    localparam int PHASE_BYTES = 46;     // least random bytes per random phase

    // One ROM byte as presented on the slave stream.
    typedef struct {
        logic [7:0]       data;
        logic             begin_sprite;
        logic [REQ_W-1:0] request;
        logic [ROM_W-1:0] offset;
    } rom_byte_t;

    // One write command into the decode buffer.
    typedef struct {
        logic [OUT_IDX_W-1:0] dest;
        logic [7:0]           first_px;
        logic [7:0]           second_px;
        logic [1:0]           count;
        logic                 run_last;
        logic                 done;
        logic                 visible;
        logic [ROM_W-1:0]     end_off;
    } pixel_write_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [ROM_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [47:0]      s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [63:0]      m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    sprite_rle_unpacker #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Bytes waiting for the driver, and the writes the decoder model says must follow.
    rom_byte_t    pending_bytes[$];
    pixel_write_t expected_writes[$];

    // Decoder model state, mirroring the block's request state and its mask register.
    phase_t               dec_phase   = PH_IDLE;
    logic [LEN_W-1:0]     run_left    = '0;
    logic [13:0]          pixels_owed = '0;
    logic [OUT_IDX_W-1:0] buf_ptr     = '0;
    logic [ROM_W-1:0]     rom_pos     = '0;
    logic                 saw_visible = 1'b0;
    logic [ROM_W-1:0]     rom_mask    = ROM_MASK_RESET;

    int send_idle_pct = 32;
    int recv_idle_pct = 59;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int writes_checked = 0;
    int sprites_done = 0;
    int mask_writes = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    rom_byte_t    cur_byte;
    pixel_write_t got_write;
    pixel_write_t want_write;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Records one expected write; the request summary is only carried on the final write.
    task automatic add_write(input logic [OUT_IDX_W-1:0] dest, input logic [7:0] p0,
                             input logic [7:0] p1, input logic [1:0] cnt,
                             input logic last, input logic done);
        pixel_write_t w;
        w.dest      = dest;
        w.first_px  = p0;
        w.second_px = p1;
        w.count     = cnt;
        w.run_last  = last;
        w.done      = done;
        w.visible   = done ? saw_visible : 1'b0;
        w.end_off   = done ? rom_pos : '0;
        expected_writes.push_back(w);
    endtask

    // Advances the decoder model by one accepted ROM byte.
    task automatic decode_rom_byte(input rom_byte_t rb);
        int   run;
        int   cnt;
        logic fin;
        logic last;
        logic done;
        if (rb.begin_sprite)
        begin
            // A begin abandons whatever request was in progress.
            pixels_owed = {1'b0, rb.request};
            rom_pos     = rb.offset & rom_mask;
            buf_ptr     = '0;
            saw_visible = 1'b0;
            run_left    = '0;
            if (pixels_owed == 0)
            begin
                // Empty request: answered at once and the byte is not consumed.
                dec_phase = PH_IDLE;
                add_write('0, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1);
                return;
            end
            dec_phase = PH_CTRL;
        end
        rom_pos = dec_phase == PH_IDLE ? rom_pos : (rom_pos + 1'b1) & rom_mask;
        case (dec_phase)
            PH_IDLE:
            begin
                // Bytes outside a request are dropped.
            end
            PH_CTRL:
            begin
                run = int'(rb.data[6:0]) + 1;
                pixels_owed = (pixels_owed > run) ? pixels_owed - 14'(run) : '0;
                run_left = LEN_W'(run);
                // A one-pixel packet is a single literal whatever bit 7 says.
                if (run == 1 || rb.data[7])
                begin
                    saw_visible = 1'b1;
                    dec_phase = PH_LIT;
                end
                else
                begin
                    dec_phase = PH_REP;
                end
            end
            PH_LIT:
            begin
                run_left = run_left - 1'b1;
                done = (run_left == 0) && (pixels_owed == 0);
                add_write(buf_ptr, rb.data, 8'h00, 2'd1, 1'b1, done);
                buf_ptr = OUT_IDX_W'((int'(buf_ptr) + 1) % BUF_DEPTH);
                if (run_left == 0)
                    dec_phase = done ? PH_IDLE : PH_CTRL;
            end
            PH_REP:
            begin
                if (rb.data != 0)
                    saw_visible = 1'b1;
                fin = (pixels_owed == 0);
                while (run_left > 0)
                begin
                    cnt = (run_left >= 2) ? 2 : 1;
                    run_left = run_left - LEN_W'(cnt);
                    last = (run_left == 0);
                    add_write(buf_ptr, rb.data, (cnt == 2) ? rb.data : 8'h00, 2'(cnt),
                              last, last && fin);
                    buf_ptr = OUT_IDX_W'((int'(buf_ptr) + cnt) % BUF_DEPTH);
                end
                dec_phase = fin ? PH_IDLE : PH_CTRL;
            end
        endcase
    endtask

    // Queues one ROM byte. Request and offset are sampled only with a begin, so on other
    // bytes they carry random junk that the block must ignore.
    task automatic push_byte(input logic [7:0] data, input logic begin_sprite,
                             input logic [REQ_W-1:0] request, input logic [ROM_W-1:0] offset);
        rom_byte_t rb;
        rb.data         = data;
        rb.begin_sprite = begin_sprite;
        rb.request      = begin_sprite ? request : REQ_W'($urandom);
        rb.offset       = begin_sprite ? offset : ROM_W'($urandom);
        pending_bytes.push_back(rb);
        bytes_queued++;
    endtask

    // Queues one sprite request made of well-formed packets with random content. Some are
    // cut short so that the next begin lands in the middle of a request. A big request
    // opens with a half-length packet so that its last packet runs past the buffer end.
    task automatic queue_sprite(input bit big, output int count);
        int               req;
        int               remaining;
        int               run;
        int               roll;
        int               stop_at;
        int               i;
        int               n;
        logic [7:0]       ctrl;
        logic [ROM_W-1:0] off;
        n = 0;
        roll = $urandom_range(99);
        if (big)
            req = $urandom_range(8191, 8129);
        else if (roll < 5)
            req = 0;
        else if (roll < 15)
            req = $urandom_range(300, 41);
        else
            req = $urandom_range(40, 1);
        off = ($urandom_range(9) == 0) ? '1 : ROM_W'($urandom);
        stop_at = (!big && $urandom_range(99) < 15) ? $urandom_range(12, 1) : -1;
        if (req == 0)
        begin
            push_byte(8'($urandom), 1'b1, '0, off);
            count = 1;
            return;
        end
        remaining = req;
        while (remaining > 0 && n != stop_at)
        begin
            roll = $urandom_range(99);
            if (big)
                run = (n == 0) ? 64 : 128;
            else if ($urandom_range(9) == 0)
                run = $urandom_range(128, 9);
            else
                run = $urandom_range(8, 1);
            if (run == 1)
                ctrl = {1'($urandom), 7'd0};
            else if (!big && roll < 50)
                ctrl = {1'b1, 7'(run - 1)};
            else
                ctrl = {1'b0, 7'(run - 1)};
            push_byte(ctrl, n == 0, REQ_W'(req), off);
            n++;
            if (ctrl[7] || run == 1)
            begin
                for (i = 0; i < run && n != stop_at; i++)
                begin
                    push_byte(8'($urandom), 1'b0, '0, '0);
                    n++;
                end
            end
            else if (n != stop_at)
            begin
                // Zero repeats are the only packets that leave the sprite invisible.
                push_byte(($urandom_range(99) < 20) ? 8'h00 : 8'($urandom), 1'b0, '0, '0);
                n++;
            end
            remaining -= run;
        end
        // Now and then a stray byte after a finished request, which must be dropped.
        if (stop_at < 0 && $urandom_range(9) == 0)
            push_byte(8'($urandom), 1'b0, '0, '0);
        count = n;
    endtask

    // Waits until every queued byte has been taken and every predicted write has come out,
    // then lets the pipeline run empty.
    task automatic wait_drained;
        while (!(bytes_accepted == bytes_queued && expected_writes.size() == 0))
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Writes the ROM address mask; only called while the block has nothing in flight.
    task automatic write_mask(input logic [ROM_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rom_mask = value;
        mask_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Short directed sequence over the corner cases.
    task automatic queue_directed;
        push_byte(8'hFF, 1'b0, '0, '0);                  // stray byte while idle
        push_byte(8'h3C, 1'b1, '0, '1);                  // empty request
        push_byte(8'h00, 1'b1, 13'd1, '0);               // single pixel, bit 7 clear
        push_byte(8'h00, 1'b0, '0, '0);
        push_byte(8'h80, 1'b1, 13'd1, 27'h0000123);      // single pixel, bit 7 set
        push_byte(8'hFF, 1'b0, '0, '0);
        push_byte(8'h01, 1'b1, 13'd2, 27'h7FFFFFE);      // zero repeat, end offset wraps
        push_byte(8'h00, 1'b0, '0, '0);
        push_byte(8'h81, 1'b1, 13'd1, 27'h0000001);      // literal packet overshoots
        push_byte(8'hFF, 1'b0, '0, '0);
        push_byte(8'h5A, 1'b0, '0, '0);
        push_byte(8'h7F, 1'b1, 13'd3, 27'h4000000);      // longest repeat, sixty-four writes
        push_byte(8'hFF, 1'b0, '0, '0);
        push_byte(8'hFF, 1'b1, 13'd8191, 27'h2AAAAAA);   // largest request, abandoned
        push_byte(8'h12, 1'b0, '0, '0);
        push_byte(8'h34, 1'b0, '0, '0);
        push_byte(8'h02, 1'b1, 13'd5, 27'h5555555);      // begin mid-literal; odd repeat
        push_byte(8'hA5, 1'b0, '0, '0);
        push_byte(8'h81, 1'b0, '0, '0);
        push_byte(8'h01, 1'b0, '0, '0);
        push_byte(8'h80, 1'b0, '0, '0);
        push_byte(8'h03, 1'b1, 13'd4, '0);               // abandoned while awaiting a value
        push_byte(8'h80, 1'b1, 13'd1, 27'h0000010);
        push_byte(8'h7F, 1'b0, '0, '0);
        push_byte(8'h00, 1'b0, '0, '0);                  // stray byte after completion
    endtask

    function automatic bit same_write(input pixel_write_t a, input pixel_write_t b);
        return a.dest === b.dest && a.first_px === b.first_px &&
               a.second_px === b.second_px && a.count === b.count &&
               a.run_last === b.run_last && a.done === b.done &&
               a.visible === b.visible && a.end_off === b.end_off;
    endfunction

    function automatic string write_text(input pixel_write_t w);
        return $sformatf("dest %0d px %02h/%02h count %0d last %0b done %0b vis %0b end %07h",
                         w.dest, w.first_px, w.second_px, w.count, w.run_last, w.done,
                         w.visible, w.end_off);
    endfunction

    // Driver: presents the next pending byte whenever the slot is free, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_rom_byte(cur_byte);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_byte.offset, cur_byte.request, cur_byte.data};
                    s_tuser  <= cur_byte.begin_sprite;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes each write transaction and checks it against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_write.dest      = m_tdata[12:0];
                got_write.first_px  = m_tdata[20:13];
                got_write.second_px = m_tdata[28:21];
                got_write.count     = m_tdata[30:29];
                got_write.visible   = m_tdata[31];
                got_write.end_off   = m_tdata[58:32];
                got_write.done      = m_tuser;
                got_write.run_last  = m_tlast;
                if (expected_writes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("testbench: unexpected write %s", write_text(got_write));
                    mismatches++;
                end
                else
                begin
                    want_write = expected_writes.pop_front();
                    writes_checked++;
                    if (want_write.done)
                        sprites_done++;
                    if (!same_write(got_write, want_write))
                    begin
                        if (mismatches < 10)
                        begin
                            $display("testbench: write mismatch at %0t", $realtime);
                            $display("    expected %s", write_text(want_write));
                            $display("    actual   %s", write_text(got_write));
                        end
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a long stretch with no transaction anywhere means the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Main sequence: one phase per mask setting. The first two phases stall the sender
    // lightly and the receiver heavily, the next two the other way round, the last two
    // run without gaps. Every phase ends on an empty request so the block is idle before
    // the mask changes.
    initial
    begin
        int               p;
        int               n;
        int               phase_count;
        logic [ROM_W-1:0] mask_value;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 32 : (p < 4) ? 59 : 0;
            recv_idle_pct = (p < 2) ? 59 : (p < 4) ? 32 : 0;
            case (p)
                0: mask_value = '1;
                1: mask_value = '0;
                2: mask_value = 27'h00000FF;
                4: mask_value = '1;
                default: mask_value = ROM_W'($urandom);
            endcase
            write_mask(mask_value);
            if (p == 0)
            begin
                queue_directed();
            end
            else
            begin
                phase_count = 0;
                // One request long enough to wrap the decode buffer.
                if (p == 4)
                    queue_sprite(1'b1, phase_count);
                while (phase_count < PHASE_BYTES)
                begin
                    queue_sprite(1'b0, n);
                    phase_count += n;
                end
            end
            push_byte(8'($urandom), 1'b1, '0, ROM_W'($urandom));
            wait_drained();
        end
        if (expected_writes.size() != 0)
        begin
            $display("testbench: %0d predicted writes never arrived", expected_writes.size());
            mismatches += expected_writes.size();
        end
        $display("testbench: %0d ROM bytes sent, %0d writes checked, %0d requests completed",
                 bytes_accepted, writes_checked, sprites_done);
        $display("testbench: %0d mask settings used, %0d mismatches", mask_writes, mismatches);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
